// File: rtl/kts_pkg.sv
// shared constants and codes for the keyframe track sampler
`timescale 1ns / 1ps
package kts_pkg;

  // table size default
  localparam int MAX_KEYS_DEF = 64;

  // register indexes on the configuration channel
  localparam logic [1:0] REG_TICKS_PER_SECOND = 2'd0;
  localparam logic [1:0] REG_TRACK_DURATION   = 2'd1;
  localparam logic [1:0] REG_KEY_COUNT        = 2'd2;
  localparam logic [1:0] REG_DEFAULT_VALUE    = 2'd3;

  // item kinds carried in tuser
  localparam logic KIND_LOAD   = 1'b0;
  localparam logic KIND_SAMPLE = 1'b1;

  // reset values and fallback tick rate (16.16)
  localparam logic [31:0] TPS_RESET     = 32'h0019_0000;
  localparam logic [31:0] TPS_FALLBACK  = 32'h0019_0000;
  localparam logic [31:0] DEFAULT_RESET = 32'h0001_0000;

  // stream widths
  localparam int IN_TDATA_W  = 168;
  localparam int OUT_TDATA_W = 96;

endpackage

// File: rtl/keyframe_track_sampler.sv
// keyframe track sampler: key table, tick scaling, wrap, interval search and lerp
`timescale 1ns / 1ps
//
// channel   direction  fields
// s_axis    in         tuser: kind; tdata: key_index, key_time, key_x, key_y, key_z, frame
// m_axis    out        tuser: in_range; tdata: out_x, out_y, out_z
// cfg       in         cfg_index, cfg_data (write only, always ready)
//
// a load item writes the key table; a sample item scales its frame to ticks,
// takes the wrap remainder (skipped when track_duration is zero), searches the keys
// and, when an interval hits, divides for the blend factor and lerps. the restoring
// divider is shared by the wrap and the blend factor. reset is synchronous; the key
// table is not cleared. s_axis_tready is low while a sample is in work; a finished
// sample holds in the output state while the previous result still waits to leave.
module keyframe_track_sampler #(
  parameter int MAX_KEYS = kts_pkg::MAX_KEYS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [5:0] key_index, [37:6] key_time, [69:38] key_x, [101:70] key_y,
  // [133:102] key_z, [165:134] frame, [167:166] zero
  input  logic [kts_pkg::IN_TDATA_W-1:0] s_axis_tdata,
  // [0] kind
  input  logic                          s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [31:0] out_x, [63:32] out_y, [95:64] out_z
  output logic [kts_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  // [0] in_range
  output logic                          m_axis_tuser,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [1:0]                    cfg_index,
  input  logic [31:0]                   cfg_data
);

  localparam int AW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
  localparam int NW = $clog2(MAX_KEYS + 1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MUL   = 4'd1;
  localparam logic [3:0] S_TICK  = 4'd2;
  localparam logic [3:0] S_MOD   = 4'd3;
  localparam logic [3:0] S_DISP  = 4'd4;
  localparam logic [3:0] S_ONEW  = 4'd5;
  localparam logic [3:0] S_ONE   = 4'd6;
  localparam logic [3:0] S_PRIME = 4'd7;
  localparam logic [3:0] S_SRCH  = 4'd8;
  localparam logic [3:0] S_FDIV  = 4'd9;
  localparam logic [3:0] S_BWAIT = 4'd10;
  localparam logic [3:0] S_LMUL  = 4'd11;
  localparam logic [3:0] S_LADD  = 4'd12;
  localparam logic [3:0] S_OUT   = 4'd13;

  logic [3:0] state;

  // configuration registers
  logic [31:0] ticks_per_second;
  logic [31:0] track_duration;
  logic [6:0]  key_count;
  logic [31:0] default_value;

  // key table
  logic [31:0] time_mem [MAX_KEYS];
  logic [31:0] x_mem    [MAX_KEYS];
  logic [31:0] y_mem    [MAX_KEYS];
  logic [31:0] z_mem    [MAX_KEYS];
  logic [31:0] time_q, x_q, y_q, z_q;
  logic [AW-1:0] rd_ptr;

  // input fields
  logic        in_kind;
  logic [5:0]  in_key_index;
  logic [31:0] in_key_time, in_key_x, in_key_y, in_key_z, in_frame;
  logic        in_acc, load_we;
  logic [AW-1:0] waddr;

  // working registers
  logic [31:0] frame;
  logic [63:0] ticks;
  logic [47:0] t;
  logic [NW-1:0] n;
  logic [NW-1:0] k;
  logic [31:0] prev;
  logic [15:0] f;
  logic [31:0] ax, ay, az;
  logic [1:0]  c;
  logic signed [49:0] prod;
  logic [31:0] res_x, res_y, res_z;
  logic        res_rng;

  // shared divider
  logic [32:0] rem;
  logic [47:0] quo;
  logic [32:0] dsr;
  logic [5:0]  dcnt;
  logic [33:0] div_sh;
  logic        div_ge;

  // lerp operand select
  logic [31:0] a_sel, b_sel;
  logic signed [32:0] diff;
  logic        hit;
  logic [31:0] rate;

  assign in_kind      = s_axis_tuser;
  assign in_key_index = s_axis_tdata[5:0];
  assign in_key_time  = s_axis_tdata[37:6];
  assign in_key_x     = s_axis_tdata[69:38];
  assign in_key_y     = s_axis_tdata[101:70];
  assign in_key_z     = s_axis_tdata[133:102];
  assign in_frame     = s_axis_tdata[165:134];

  assign s_axis_tready = (state == S_IDLE);
  assign cfg_ready     = 1'b1;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign load_we       = in_acc && (in_kind == kts_pkg::KIND_LOAD) &&
                         (32'(in_key_index) < MAX_KEYS);
  assign waddr         = AW'(in_key_index);

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      ticks_per_second <= kts_pkg::TPS_RESET;
      track_duration   <= '0;
      key_count        <= '0;
      default_value    <= kts_pkg::DEFAULT_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        kts_pkg::REG_TICKS_PER_SECOND: ticks_per_second <= cfg_data;
        kts_pkg::REG_TRACK_DURATION:   track_duration   <= cfg_data;
        kts_pkg::REG_KEY_COUNT:        key_count        <= cfg_data[6:0];
        kts_pkg::REG_DEFAULT_VALUE:    default_value    <= cfg_data;
        default: ;
      endcase
    end
  end

  // key table write and registered reads
  always_ff @(posedge clk) begin
    if (load_we) begin
      time_mem[waddr] <= in_key_time;
      x_mem[waddr]    <= in_key_x;
      y_mem[waddr]    <= in_key_y;
      z_mem[waddr]    <= in_key_z;
    end
    time_q <= time_mem[rd_ptr];
    x_q    <= x_mem[rd_ptr];
    y_q    <= y_mem[rd_ptr];
    z_q    <= z_mem[rd_ptr];
  end

  // divider step and compare
  assign div_sh = {rem, quo[47]};
  assign div_ge = div_sh >= {1'b0, dsr};

  // search compare and lerp operands
  assign hit  = (k != '0) && (t >= {16'b0, prev}) && (t < {16'b0, time_q});
  assign rate = (ticks_per_second != '0) ? ticks_per_second : kts_pkg::TPS_FALLBACK;

  always_comb begin
    case (c)
      2'd0:    begin a_sel = ax; b_sel = x_q; end
      2'd1:    begin a_sel = ay; b_sel = y_q; end
      default: begin a_sel = az; b_sel = z_q; end
    endcase
  end
  assign diff = $signed({b_sel[31], b_sel}) - $signed({a_sel[31], a_sel});

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      m_axis_tvalid <= 1'b0;
      dcnt          <= '0;
    end else begin
      // output register empties unless the output state refills it this cycle
      if (m_axis_tvalid && m_axis_tready && (state != S_OUT)) begin
        m_axis_tvalid <= 1'b0;
      end
      // divider runs whenever its count is live
      if (dcnt != '0) begin
        rem  <= div_ge ? 33'(div_sh - {1'b0, dsr}) : 33'(div_sh);
        quo  <= {quo[46:0], div_ge};
        dcnt <= dcnt - 6'd1;
      end
      unique case (state)
        S_IDLE: begin
          if (in_acc && (in_kind == kts_pkg::KIND_SAMPLE)) begin
            frame <= in_frame;
            n     <= (32'(key_count) > MAX_KEYS) ? NW'(MAX_KEYS) : NW'(key_count);
            state <= S_MUL;
          end
        end
        S_MUL: begin
          ticks <= 64'(frame) * 64'(rate);
          state <= S_TICK;
        end
        S_TICK: begin
          if (track_duration == '0) begin
            t     <= ticks[63:16];
            state <= S_DISP;
          end else begin
            rem   <= '0;
            quo   <= ticks[63:16];
            dsr   <= {1'b0, track_duration};
            dcnt  <= 6'd48;
            state <= S_MOD;
          end
        end
        S_MOD: begin
          if (dcnt == '0) begin
            t     <= {15'b0, rem};
            state <= S_DISP;
          end
        end
        S_DISP: begin
          rd_ptr <= '0;
          k      <= '0;
          if (n == '0) begin
            res_x   <= default_value;
            res_y   <= default_value;
            res_z   <= default_value;
            res_rng <= 1'b0;
            state   <= S_OUT;
          end else if (n == NW'(1)) begin
            state <= S_ONEW;
          end else begin
            state <= S_PRIME;
          end
        end
        S_ONEW: state <= S_ONE;
        S_ONE: begin
          res_x   <= x_q;
          res_y   <= y_q;
          res_z   <= z_q;
          res_rng <= 1'b1;
          state   <= S_OUT;
        end
        S_PRIME: begin
          rd_ptr <= rd_ptr + AW'(1);
          state  <= S_SRCH;
        end
        S_SRCH: begin
          if (hit) begin
            rem    <= {1'b0, t[31:0] - prev};
            quo    <= '0;
            dsr    <= {1'b0, time_q - prev};
            dcnt   <= 6'd16;
            rd_ptr <= AW'(k - NW'(1));
            state  <= S_FDIV;
          end else if (k == n - NW'(1)) begin
            res_x   <= default_value;
            res_y   <= default_value;
            res_z   <= default_value;
            res_rng <= 1'b0;
            state   <= S_OUT;
          end else begin
            prev   <= time_q;
            k      <= k + NW'(1);
            rd_ptr <= rd_ptr + AW'(1);
          end
        end
        S_FDIV: begin
          if (dcnt == '0) begin
            f      <= quo[15:0];
            ax     <= x_q;
            ay     <= y_q;
            az     <= z_q;
            rd_ptr <= rd_ptr + AW'(1);
            state  <= S_BWAIT;
          end
        end
        S_BWAIT: begin
          c     <= 2'd0;
          state <= S_LMUL;
        end
        S_LMUL: begin
          prod  <= 50'(diff * $signed({1'b0, f}));
          state <= S_LADD;
        end
        S_LADD: begin
          case (c)
            2'd0:    res_x <= a_sel + prod[47:16];
            2'd1:    res_y <= a_sel + prod[47:16];
            default: res_z <= a_sel + prod[47:16];
          endcase
          res_rng <= 1'b1;
          if (c == 2'd2) begin
            state <= S_OUT;
          end else begin
            c     <= c + 2'd1;
            state <= S_LMUL;
          end
        end
        S_OUT: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tdata  <= {res_z, res_y, res_x};
            m_axis_tuser  <= res_rng;
            m_axis_tvalid <= 1'b1;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/kts_checker.sv
// port level checks for the keyframe track sampler, bound to the top level
`timescale 1ns / 1ps
module kts_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic [kts_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  input logic                           s_axis_tuser,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [kts_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input logic                           m_axis_tuser
);

  // a stalled result stays offered
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // a stalled result keeps its data
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result data changed while stalled");

  // a load transaction never raises a result next cycle
  assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser == kts_pkg::KIND_LOAD)
    |=> !$rose(m_axis_tvalid))
    else $error("load produced a result");

  // a sample transaction blocks the input while it is worked
  assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser == kts_pkg::KIND_SAMPLE)
    |=> !s_axis_tready)
    else $error("input ready during sample");

  // the default fills all three components alike
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser |->
      (m_axis_tdata[31:0] == m_axis_tdata[63:32]) &&
      (m_axis_tdata[31:0] == m_axis_tdata[95:64]))
    else $error("default result not uniform");

endmodule

bind keyframe_track_sampler kts_checker u_kts_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
